FILE: src/lsp_pkg.sv
// Shared types and constants for the linear-density inverse-CDF sampler.
// No dependencies; every other file imports this package.
package lsp_pkg;

	// Fixed-point formats
	localparam int FRAC_BITS = 16;
	localparam int RAND_BITS = 16;
	localparam int DATA_W    = 32;

	// Discriminant, root and quotient widths
	localparam int D_W      = 128;
	localparam int ROOT_W   = 64;
	localparam int REM_W    = ROOT_W + 3;
	localparam int NUM_W    = ROOT_W + 2;
	localparam int NUMS_W   = NUM_W + 1;
	localparam int G_W      = 2 * DATA_W + RAND_BITS + 1;
	localparam int GS_L     = (2 * FRAC_BITS >= RAND_BITS) ? 2 * FRAC_BITS - RAND_BITS : 0;
	localparam int GS_R     = (2 * FRAC_BITS >= RAND_BITS) ? 0 : RAND_BITS - 2 * FRAC_BITS;

	// Register map
	localparam int ADDR_W = 5;
	localparam logic [2:0] REG_SLOPE     = 3'd0;
	localparam logic [2:0] REG_INTERCEPT = 3'd1;
	localparam logic [2:0] REG_PWIDTH    = 3'd2;
	localparam logic [2:0] REG_RLOW      = 3'd3;
	localparam logic [2:0] REG_RHIGH     = 3'd4;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_SLOPE0  = 2'd1,
		ST_NEGDISC = 2'd2,
		ST_OVF     = 2'd3
	} status_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] slope;
		logic signed [DATA_W-1:0] intercept;
		logic signed [DATA_W-1:0] pwidth;
		logic signed [DATA_W-1:0] rlow;
		logic signed [DATA_W-1:0] rhigh;
	} cfg_t;

	// front end -> square root
	typedef struct packed {
		logic [D_W-1:0] d;
		status_t        st;
	} disc_t;

	// square root -> divider
	typedef struct packed {
		logic [ROOT_W-1:0] root;
		status_t           st;
	} root_t;

	// divider -> select stage
	typedef struct packed {
		logic [DATA_W-1:0] x1;
		logic              ovf1;
		logic [DATA_W-1:0] x2;
		logic              ovf2;
		status_t           st;
	} quot_t;

endpackage

FILE: src/lsp_cfg.sv
// APB register file holding the five sampler settings.
// Depends on lsp_pkg.
module lsp_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [lsp_pkg::ADDR_W-1:0]  paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	output lsp_pkg::cfg_t               cfg
);
	import lsp_pkg::*;

	cfg_t       cfg_q;
	logic [2:0] idx;
	logic       wr;

	assign idx    = paddr[4:2];
	assign wr     = psel & penable & pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	// register writes; indexes past the map are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.slope     <= 32'sd65536;
			cfg_q.intercept <= '0;
			cfg_q.pwidth    <= 32'sd65536;
			cfg_q.rlow      <= '0;
			cfg_q.rhigh     <= 32'sd65536;
		end else if (wr) begin
			unique case (idx)
				REG_SLOPE:     cfg_q.slope     <= pwdata;
				REG_INTERCEPT: cfg_q.intercept <= pwdata;
				REG_PWIDTH:    cfg_q.pwidth    <= pwdata;
				REG_RLOW:      cfg_q.rlow      <= pwdata;
				REG_RHIGH:     cfg_q.rhigh     <= pwdata;
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		unique case (idx)
			REG_SLOPE:     prdata = cfg_q.slope;
			REG_INTERCEPT: prdata = cfg_q.intercept;
			REG_PWIDTH:    prdata = cfg_q.pwidth;
			REG_RLOW:      prdata = cfg_q.rlow;
			REG_RHIGH:     prdata = cfg_q.rhigh;
			default:       prdata = '0;
		endcase
	end

endmodule

FILE: src/lsp_front.sv
// Six-stage front end: forms the discriminant (alpha*a+beta)^2 + 2*alpha*gamma*u.
// Depends on lsp_pkg.
module lsp_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  lsp_pkg::cfg_t                  cfg,
	input  logic                           in_valid,
	input  logic [lsp_pkg::RAND_BITS-1:0]  u,
	output logic                           out_valid,
	output lsp_pkg::disc_t                 out
);
	import lsp_pkg::*;

	logic [5:0] v_s;

	logic [DATA_W-1:0] amag, gmag;
	logic [2*DATA_W-1:0] bf;

	logic signed [2*DATA_W-1:0] prod_aa_s1;
	logic [2*DATA_W-1:0]        prod_ag_s1;
	logic [RAND_BITS:0]         u2_s1;
	logic                       gneg_s1, slope0_s1;

	logic [2*DATA_W-1:0]        c_s2;
	logic [DATA_W+RAND_BITS:0]  glo_s2, ghi_s2;
	logic                       gneg_s2, slope0_s2;

	logic [2*DATA_W-1:0] cm_s3;
	logic [G_W-1:0]      g_s3;
	logic                gneg_s3, slope0_s3;

	logic [2*DATA_W-1:0] ll_s4, lh_s4, hh_s4;
	logic [D_W-1:0]      gs_s4;
	logic                gneg_s4, slope0_s4;

	logic [D_W-1:0] sq_s5, gs_s5;
	logic           gneg_s5, slope0_s5;

	logic [D_W-1:0] d_s6;
	logic           slope0_s6;

	assign amag = cfg.slope[DATA_W-1] ? (~cfg.slope + 1'b1) : cfg.slope;
	assign gmag = cfg.pwidth[DATA_W-1] ? (~cfg.pwidth + 1'b1) : cfg.pwidth;
	assign bf   = {{(DATA_W-FRAC_BITS){cfg.intercept[DATA_W-1]}}, cfg.intercept,
		{FRAC_BITS{1'b0}}};

	// valid shift
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else begin
			v_s <= {v_s[4:0], in_valid};
		end
	end

	// datapath stages
	always_ff @(posedge clk) begin
		// s1: the two 32x32 products
		prod_aa_s1 <= (2*DATA_W)'(cfg.slope) * (2*DATA_W)'(cfg.rlow);
		prod_ag_s1 <= (2*DATA_W)'(amag) * (2*DATA_W)'(gmag);
		u2_s1      <= {u, 1'b0};
		gneg_s1    <= cfg.slope[DATA_W-1] ^ cfg.pwidth[DATA_W-1];
		slope0_s1  <= (cfg.slope == '0);
		// s2: c = alpha*a + beta, split g product
		c_s2      <= prod_aa_s1 + bf;
		glo_s2    <= (DATA_W+RAND_BITS+1)'(prod_ag_s1[DATA_W-1:0]) *
			(DATA_W+RAND_BITS+1)'(u2_s1);
		ghi_s2    <= (DATA_W+RAND_BITS+1)'(prod_ag_s1[2*DATA_W-1:DATA_W]) *
			(DATA_W+RAND_BITS+1)'(u2_s1);
		gneg_s2   <= gneg_s1;
		slope0_s2 <= slope0_s1;
		// s3: |c|, join g halves
		cm_s3     <= c_s2[2*DATA_W-1] ? (~c_s2 + 1'b1) : c_s2;
		g_s3      <= G_W'(glo_s2) + (G_W'(ghi_s2) << DATA_W);
		gneg_s3   <= gneg_s2;
		slope0_s3 <= slope0_s2;
		// s4: partial squares, align g to the 4F scale
		ll_s4     <= (2*DATA_W)'(cm_s3[DATA_W-1:0]) * (2*DATA_W)'(cm_s3[DATA_W-1:0]);
		lh_s4     <= (2*DATA_W)'(cm_s3[DATA_W-1:0]) * (2*DATA_W)'(cm_s3[2*DATA_W-1:DATA_W]);
		hh_s4     <= (2*DATA_W)'(cm_s3[2*DATA_W-1:DATA_W]) *
			(2*DATA_W)'(cm_s3[2*DATA_W-1:DATA_W]);
		gs_s4     <= (D_W'(g_s3) << GS_L) >> GS_R;
		gneg_s4   <= gneg_s3;
		slope0_s4 <= slope0_s3;
		// s5: c^2
		sq_s5     <= D_W'(ll_s4) + (D_W'(lh_s4) << (DATA_W+1)) + (D_W'(hh_s4) << (2*DATA_W));
		gs_s5     <= gs_s4;
		gneg_s5   <= gneg_s4;
		slope0_s5 <= slope0_s4;
		// s6: discriminant
		d_s6      <= gneg_s5 ? (sq_s5 - gs_s5) : (sq_s5 + gs_s5);
		slope0_s6 <= slope0_s5;
	end

	assign out_valid = v_s[5];
	assign out.d     = d_s6;
	assign out.st    = slope0_s6 ? ST_SLOPE0 : (d_s6[D_W-1] ? ST_NEGDISC : ST_OK);

endmodule

FILE: src/lsp_sqrt.sv
// Bit-per-stage integer square root of the 128-bit discriminant (64 stages).
// Depends on lsp_pkg.
module lsp_sqrt (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  lsp_pkg::disc_t  in,
	output logic            out_valid,
	output lsp_pkg::root_t  out
);
	import lsp_pkg::*;

	typedef struct packed {
		logic [REM_W-1:0]  rem;
		logic [ROOT_W-1:0] root;
		logic [D_W-1:0]    dsh;
		status_t           st;
	} sq_t;

	sq_t  sq_s [1:ROOT_W];
	logic v_s  [1:ROOT_W];

	for (genvar k = 0; k < ROOT_W; k++) begin : g_step
		sq_t  cur, nxt;
		logic cur_v;
		logic [REM_W-1:0] rem_n, trial;

		if (k == 0) begin : g_first
			assign cur   = '{rem: '0, root: '0, dsh: in.d, st: in.st};
			assign cur_v = in_valid;
		end else begin : g_next
			assign cur   = sq_s[k];
			assign cur_v = v_s[k];
		end

		// one root bit: bring down two bits, try (root<<2)|1
		always_comb begin
			rem_n    = {cur.rem[REM_W-3:0], cur.dsh[D_W-1:D_W-2]};
			trial    = {1'b0, cur.root, 2'b01};
			nxt      = cur;
			nxt.dsh  = {cur.dsh[D_W-3:0], 2'b00};
			if (rem_n >= trial) begin
				nxt.rem  = rem_n - trial;
				nxt.root = {cur.root[ROOT_W-2:0], 1'b1};
			end else begin
				nxt.rem  = rem_n;
				nxt.root = {cur.root[ROOT_W-2:0], 1'b0};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else begin
				v_s[k+1] <= cur_v;
			end
		end

		always_ff @(posedge clk) begin
			sq_s[k+1] <= nxt;
		end
	end

	assign out_valid = v_s[ROOT_W];
	assign out.root  = sq_s[ROOT_W].root;
	assign out.st    = sq_s[ROOT_W].st;

endmodule

FILE: src/lsp_div.sv
// Both roots: numerators s-beta and -beta-s, then two bit-per-stage dividers
// by |alpha| with truncation and 32-bit saturation. Depends on lsp_pkg.
module lsp_div (
	input  logic            clk,
	input  logic            arst_n,
	input  lsp_pkg::cfg_t   cfg,
	input  logic            in_valid,
	input  lsp_pkg::root_t  in,
	output logic            out_valid,
	output lsp_pkg::quot_t  out
);
	import lsp_pkg::*;

	typedef struct packed {
		logic [DATA_W-1:0] r1;
		logic [NUM_W-1:0]  nq1;
		logic              neg1;
		logic [DATA_W-1:0] r2;
		logic [NUM_W-1:0]  nq2;
		logic              neg2;
		status_t           st;
	} dv_t;

	logic [DATA_W-1:0] amag;
	logic [NUMS_W-1:0] bf, sx;

	logic [NUMS_W-1:0] n1_s1, n2_s1;
	status_t           st_s1;
	logic              v_s1;

	dv_t  dv_s [0:NUM_W];
	logic v_s  [0:NUM_W];

	quot_t q_q;
	logic  v_q;

	assign amag = cfg.slope[DATA_W-1] ? (~cfg.slope + 1'b1) : cfg.slope;
	assign bf   = {{(NUMS_W-DATA_W-FRAC_BITS){cfg.intercept[DATA_W-1]}}, cfg.intercept,
		{FRAC_BITS{1'b0}}};
	assign sx   = NUMS_W'(in.root);

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s[0]  <= 1'b0;
			v_q     <= 1'b0;
		end else begin
			v_s1    <= in_valid;
			v_s[0]  <= v_s1;
			v_q     <= v_s[NUM_W];
		end
	end

	// numerators, then magnitudes and quotient signs
	always_ff @(posedge clk) begin
		n1_s1 <= sx - bf;
		n2_s1 <= '0 - bf - sx;
		st_s1 <= in.st;
		dv_s[0].r1   <= '0;
		dv_s[0].nq1  <= n1_s1[NUMS_W-1] ? NUM_W'(~n1_s1 + 1'b1) : n1_s1[NUM_W-1:0];
		dv_s[0].neg1 <= n1_s1[NUMS_W-1] ^ cfg.slope[DATA_W-1];
		dv_s[0].r2   <= '0;
		dv_s[0].nq2  <= n2_s1[NUMS_W-1] ? NUM_W'(~n2_s1 + 1'b1) : n2_s1[NUM_W-1:0];
		dv_s[0].neg2 <= n2_s1[NUMS_W-1] ^ cfg.slope[DATA_W-1];
		dv_s[0].st   <= st_s1;
	end

	// restoring division, one quotient bit per stage for each lane
	for (genvar k = 0; k < NUM_W; k++) begin : g_step
		dv_t nxt;
		logic [DATA_W:0] rn1, rn2;
		logic            ge1, ge2;

		always_comb begin
			nxt = dv_s[k];
			rn1 = {dv_s[k].r1, dv_s[k].nq1[NUM_W-1]};
			rn2 = {dv_s[k].r2, dv_s[k].nq2[NUM_W-1]};
			ge1 = rn1 >= {1'b0, amag};
			ge2 = rn2 >= {1'b0, amag};
			nxt.r1  = ge1 ? DATA_W'(rn1 - {1'b0, amag}) : rn1[DATA_W-1:0];
			nxt.r2  = ge2 ? DATA_W'(rn2 - {1'b0, amag}) : rn2[DATA_W-1:0];
			nxt.nq1 = {dv_s[k].nq1[NUM_W-2:0], ge1};
			nxt.nq2 = {dv_s[k].nq2[NUM_W-2:0], ge2};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			dv_s[k+1] <= nxt;
		end
	end

	// range check and saturation
	localparam logic [NUM_W-1:0] LIM_POS = NUM_W'({1'b0, {(DATA_W-1){1'b1}}});
	localparam logic [NUM_W-1:0] LIM_NEG = NUM_W'({1'b1, {(DATA_W-1){1'b0}}});
	localparam logic [DATA_W-1:0] SAT_POS = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic [DATA_W-1:0] SAT_NEG = {1'b1, {(DATA_W-1){1'b0}}};

	dv_t  fin;
	logic ok1, ok2;
	logic [DATA_W-1:0] m1, m2;

	always_comb begin
		fin = dv_s[NUM_W];
		ok1 = fin.nq1 <= (fin.neg1 ? LIM_NEG : LIM_POS);
		ok2 = fin.nq2 <= (fin.neg2 ? LIM_NEG : LIM_POS);
		m1  = fin.nq1[DATA_W-1:0];
		m2  = fin.nq2[DATA_W-1:0];
	end

	always_ff @(posedge clk) begin
		q_q.x1   <= ok1 ? (fin.neg1 ? (~m1 + 1'b1) : m1) : (fin.neg1 ? SAT_NEG : SAT_POS);
		q_q.ovf1 <= !ok1;
		q_q.x2   <= ok2 ? (fin.neg2 ? (~m2 + 1'b1) : m2) : (fin.neg2 ? SAT_NEG : SAT_POS);
		q_q.ovf2 <= !ok2;
		q_q.st   <= fin.st;
	end

	assign out_valid = v_q;
	assign out       = q_q;

endmodule

FILE: src/linear_pdf_inverse_cdf_sampler.sv
// Top level of the linear-density inverse-CDF sampler.
// Depends on lsp_pkg, lsp_cfg, lsp_front, lsp_sqrt and lsp_div.
//
// Usage:
//   Settings (slope, intercept, probability_width, range_low, range_high,
//   signed Q16.16) are written over the APB port at byte addresses 0..16
//   while no sample is in flight. Reads return the stored values.
//   A uniform_fraction word is taken at each clock edge with start high;
//   busy is never raised, so one word can enter every cycle.
//   Each word yields one result word (energy, status) on the cycle done
//   is high, after passing through the multiply-and-add stages, 64
//   square-root stages (one root bit each), the numerator registers, 66
//   divider stages (one quotient bit each), the saturation register and
//   the root-select register.
//   Sustained rate is one word per cycle; results leave in input order.
//   The receiver cannot stall, so results are never held back.
//   Reset clears all pipeline valid bits and loads the default settings
//   (slope 1.0, gamma 1.0, range [0,1], intercept 0).
module linear_pdf_inverse_cdf_sampler (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [lsp_pkg::ADDR_W-1:0]    paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	input  logic                          start,
	output logic                          busy,
	input  logic [lsp_pkg::RAND_BITS-1:0] uniform_fraction,
	output logic                          done,
	output logic signed [31:0]            energy,
	output logic [1:0]                    status
);
	import lsp_pkg::*;

	cfg_t  cfg;
	logic  f_valid, r_valid, q_valid;
	disc_t f_out;
	root_t r_out;
	quot_t q_out;

	logic signed [DATA_W-1:0] lo, hi;
	logic                     x1_ok;

	logic                     done_q;
	logic signed [DATA_W-1:0] energy_q;
	status_t                  status_q;

	assign busy = 1'b0;

	lsp_cfg u_cfg (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata,
		.prdata, .pready, .cfg
	);

	lsp_front u_front (
		.clk, .arst_n, .cfg,
		.in_valid (start),
		.u        (uniform_fraction),
		.out_valid(f_valid),
		.out      (f_out)
	);

	lsp_sqrt u_sqrt (
		.clk, .arst_n,
		.in_valid (f_valid),
		.in       (f_out),
		.out_valid(r_valid),
		.out      (r_out)
	);

	lsp_div u_div (
		.clk, .arst_n, .cfg,
		.in_valid (r_valid),
		.in       (r_out),
		.out_valid(q_valid),
		.out      (q_out)
	);

	// first root wins when it fits and lies in [min(a,b), max(a,b)]
	always_comb begin
		lo    = (cfg.rlow < cfg.rhigh) ? cfg.rlow : cfg.rhigh;
		hi    = (cfg.rlow < cfg.rhigh) ? cfg.rhigh : cfg.rlow;
		x1_ok = !q_out.ovf1 && ($signed(q_out.x1) >= lo) && ($signed(q_out.x1) <= hi);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= q_valid;
		end
	end

	// result word
	always_ff @(posedge clk) begin
		if (q_out.st != ST_OK) begin
			energy_q <= '0;
			status_q <= q_out.st;
		end else if (x1_ok) begin
			energy_q <= q_out.x1;
			status_q <= ST_OK;
		end else begin
			energy_q <= q_out.x2;
			status_q <= q_out.ovf2 ? ST_OVF : ST_OK;
		end
	end

	assign done   = done_q;
	assign energy = energy_q;
	assign status = status_q;

endmodule
